// ----- hdl/ukstk_pkg.sv -----
// Package for the unique-key stack: operation and status codes, field widths,
// memory control struct. No dependencies.
`timescale 1ns / 1ps

package ukstk_pkg;

    localparam int DATA_W  = 32;  // key and value width
    localparam int COUNT_W = 5;   // reported entry count width

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Memory strobes from the sequencer to the pair store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ----- hdl/ukstk_if.sv -----
// Handshake interfaces for the command and response channels.
// Depends on ukstk_pkg for field widths.
`timescale 1ns / 1ps

interface ukstk_cmd_if;
    import ukstk_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic signed [DATA_W-1:0] entry_key;
    logic signed [DATA_W-1:0] entry_value;

    modport source (output valid, output op, output entry_key, output entry_value,
                    input ready);
    modport sink   (input valid, input op, input entry_key, input entry_value,
                    output ready);
endinterface

interface ukstk_rsp_if;
    import ukstk_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] top_key;
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;

    modport source (output valid, output status, output top_key, output top_value,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input top_key, input top_value,
                    input entry_count, input is_empty, output ready);
endinterface

// ----- hdl/ukstk_ram.sv -----
// Simple dual-port synchronous RAM holding the stacked key/value pairs.
// Registered read data. Depends on ukstk_pkg.
`timescale 1ns / 1ps

module ukstk_ram
    import ukstk_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/ukstk_seq.sv -----
// Sequencer: key scan, top read, push write-back, fill level and response register.
// Depends on ukstk_pkg and the channel interfaces; drives ukstk_ram.
`timescale 1ns / 1ps

module ukstk_seq
    import ukstk_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ukstk_cmd_if.sink                      i_cmd,
    ukstk_rsp_if.source                    o_rsp,
    output t_mem_ctl                       o_mem_ctl,
    output logic [$clog2(STACK_DEPTH)-1:0] o_rd_addr,
    output logic [$clog2(STACK_DEPTH)-1:0] o_wr_addr,
    output logic [2*DATA_W-1:0]            o_wr_data,
    input  logic [2*DATA_W-1:0]            i_rd_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_LVL = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FIN
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [DATA_W-1:0]   r_key;
    logic [DATA_W-1:0]   r_value;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_idx;
    logic                r_cmp_valid;
    logic                r_hit;

    logic                r_out_valid;
    t_status             r_status;
    logic [DATA_W-1:0]   r_top_key;
    logic [DATA_W-1:0]   r_top_value;
    logic [COUNT_W-1:0]  r_count;
    logic                r_empty;

    t_status             n_status;
    logic [DATA_W-1:0]   n_top_key;
    logic [DATA_W-1:0]   n_top_value;
    logic [CW-1:0]       n_fill;

    logic                w_acc;
    logic                w_hit;
    logic                w_issue;
    logic                w_out_free;
    logic                w_scan_done;
    logic                w_push_ok;
    logic [CW-1:0]       w_top_idx;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // key half sits in the upper bits of the stored word
    assign w_hit       = r_cmp_valid && (i_rd_data[2*DATA_W-1 -: DATA_W] == r_key);
    assign w_issue     = (r_state == S_SCAN) && (r_idx != r_fill) && !r_hit;
    assign w_scan_done = w_hit || ((r_idx == r_fill) && !r_cmp_valid);
    assign w_top_idx   = r_fill - 1'b1;
    assign w_push_ok   = (r_op == OP_PUSH) && !r_hit && (r_fill != FULL_LVL);

    assign o_mem_ctl.rd_en = w_issue || (r_state == S_READ);
    assign o_mem_ctl.wr_en = (r_state == S_FIN) && w_out_free && w_push_ok;
    assign o_rd_addr = (r_state == S_READ) ? w_top_idx[AW-1:0] : r_idx[AW-1:0];
    assign o_wr_addr = r_fill[AW-1:0];
    assign o_wr_data = {r_key, r_value};

    always_comb begin
        n_status    = ST_OK;
        n_top_key   = '0;
        n_top_value = '0;
        n_fill      = r_fill;
        unique case (r_op)
            OP_PUSH: begin
                if (r_hit) begin
                    n_status = ST_DUP;
                end else if (r_fill == FULL_LVL) begin
                    n_status = ST_FULL;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            OP_POP, OP_PEEK: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_top_key   = i_rd_data[2*DATA_W-1 -: DATA_W];
                    n_top_value = i_rd_data[DATA_W-1:0];
                    if (r_op == OP_POP) begin
                        n_fill = w_top_idx;
                    end
                end
            end
            OP_NOP: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_idx       <= '0;
                        r_cmp_valid <= 1'b0;
                        r_hit       <= 1'b0;
                        if (t_op'(i_cmd.op) == OP_PUSH) begin
                            r_state <= S_SCAN;
                        end else if ((t_op'(i_cmd.op) != OP_NOP) && (r_fill != '0)) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_cmp_valid <= w_issue;
                    if (w_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_READ: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_fill      <= n_fill;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op    <= t_op'(i_cmd.op);
            r_key   <= i_cmd.entry_key;
            r_value <= i_cmd.entry_value;
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_status    <= n_status;
            r_top_key   <= n_top_key;
            r_top_value <= n_top_value;
            r_count     <= COUNT_W'(n_fill);
            r_empty     <= (n_fill == '0);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.top_key     = r_top_key;
    assign o_rsp.top_value   = r_top_value;
    assign o_rsp.entry_count = r_count;
    assign o_rsp.is_empty    = r_empty;

endmodule

// ----- hdl/unique_key_stack.sv -----
// Response timing: a push first runs the key scan, reading one stored pair per cycle
//   until a key match or the fill level is reached; pop and peek read the top pair;
//   empty pop or peek and the unused op code go straight to the response.
// Throughput: one transaction at a time; a new command is taken the cycle after the
//   response is registered, even while that response is still waiting to be taken.
// Reset: synchronous, active low; clears the fill level, sequencer state and handshake state only.
`timescale 1ns / 1ps

// Top level. Depends on ukstk_pkg, ukstk_if, ukstk_ram and ukstk_seq.
module unique_key_stack
    import ukstk_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ukstk_cmd_if.sink   i_cmd,
    ukstk_rsp_if.source o_rsp
);

    localparam int AW = $clog2(STACK_DEPTH);

    // Each RAM word is {key, value}; entry fill-1 is the top of the stack.
    t_mem_ctl              w_mem_ctl;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [2*DATA_W-1:0]   w_wr_data;
    logic [2*DATA_W-1:0]   w_rd_data;

    // Sequencer: scans keys for duplicates on push, reads the top on pop/peek,
    // writes the new pair back at the end of a clean push, and holds the
    // response register that decouples the two channels.
    ukstk_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_rsp     (o_rsp),
        .o_mem_ctl (w_mem_ctl),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .i_rd_data (w_rd_data)
    );

    // Pair store. Never read and written in the same cycle, as every
    // transaction writes only in its final cycle and reads before it.
    ukstk_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (2 * DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

// ----- hdl/ukstk_checker.sv -----
// Port-level checks for unique_key_stack, bound to the top level.
// Depends on ukstk_pkg for codes and widths.
`timescale 1ns / 1ps

module ukstk_checker
    import ukstk_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cmd_valid,
    input logic               i_cmd_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [1:0]         i_status,
    input logic [DATA_W-1:0]  i_top_key,
    input logic [DATA_W-1:0]  i_top_value,
    input logic [COUNT_W-1:0] i_entry_count,
    input logic               i_is_empty
);

    // one transaction in flight: no command taken right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !(i_cmd_valid && i_cmd_ready))
        else $error("command accepted on consecutive cycles");

    // failed operations return no pair
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status != ST_OK)) |-> ((i_top_key == '0) && (i_top_value == '0)))
        else $error("pair data non-zero on failed operation");

    // empty flag implies zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_is_empty) |-> (i_entry_count == '0))
        else $error("empty flag with non-zero count");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_top_key) &&
             $stable(i_top_value) && $stable(i_entry_count) && $stable(i_is_empty)))
        else $error("stalled response changed");

endmodule

bind unique_key_stack ukstk_checker u_ukstk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_top_key     (o_rsp.top_key),
    .i_top_value   (o_rsp.top_value),
    .i_entry_count (o_rsp.entry_count),
    .i_is_empty    (o_rsp.is_empty)
);

// ----- verif/ukstk_shadow.sv -----
// Shadow stack and reply checker for the unique-key stack.
// Depends on ukstk_pkg and the ukstk_cmd_if / ukstk_rsp_if channel interfaces.
`timescale 1ns / 1ps

module ukstk_shadow
    import ukstk_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ukstk_cmd_if  i_cmd,
    ukstk_rsp_if  i_rsp,
    output int    o_mismatches,
    output int    o_pending
);

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_reply;

    logic [DATA_W-1:0] key_mem   [DEPTH];
    logic [DATA_W-1:0] value_mem [DEPTH];
    int                depth_used;
    t_reply            replies_due [$];
    int                reply_no;

    // Applies one command to the shadow stack and returns the reply it owes.
    function automatic t_reply apply_op(input t_op op, input logic [DATA_W-1:0] key,
                                        input logic [DATA_W-1:0] value);
        t_reply r;
        bit     seen;
        r    = '0;
        seen = 1'b0;
        case (op)
            OP_PUSH: begin
                // key scan runs before the full check
                for (int i = 0; i < depth_used; i++)
                    if (key_mem[i] == key)
                        seen = 1'b1;
                if (seen) begin
                    r.status = ST_DUP;
                end else if (depth_used >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    key_mem[depth_used]   = key;
                    value_mem[depth_used] = value;
                    depth_used++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (depth_used == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key   = key_mem[depth_used-1];
                    r.value = value_mem[depth_used-1];
                    if (op == OP_POP)
                        depth_used--;
                end
            end
            default: ;
        endcase
        r.count = depth_used[COUNT_W-1:0];
        r.empty = (depth_used == 0);
        return r;
    endfunction

    task automatic report(input string what, input logic [DATA_W-1:0] got,
                          input logic [DATA_W-1:0] want);
        $display("[%0t] reply %0d %s: got %h, want %h", $realtime, reply_no, what, got, want);
        o_mismatches++;
    endtask

    task automatic check_field(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    // Replies are taken before commands: a reply never belongs to a command
    // accepted on the same edge.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            depth_used   = 0;
            reply_no     = 0;
            o_mismatches = 0;
            replies_due.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (replies_due.size() == 0) begin
                    report("reply with nothing due", DATA_W'(i_rsp.status), '0);
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", DATA_W'(i_rsp.status), DATA_W'(want.status));
                    check_field("top_key", i_rsp.top_key, want.key);
                    check_field("top_value", i_rsp.top_value, want.value);
                    check_field("entry_count", DATA_W'(i_rsp.entry_count),
                                DATA_W'(want.count));
                    check_field("is_empty", DATA_W'(i_rsp.is_empty), DATA_W'(want.empty));
                end
                reply_no++;
            end
            if (i_cmd.valid && i_cmd.ready)
                replies_due.push_back(apply_op(t_op'(i_cmd.op), i_cmd.entry_key,
                                               i_cmd.entry_value));
        end
        o_pending <= replies_due.size();
    end

endmodule

// ----- verif/tb_unique_key_stack.sv -----
// Testbench top for the unique-key stack: clock, reset, command and reply traffic, verdict.
// Depends on ukstk_pkg, ukstk_if, unique_key_stack and the ukstk_shadow checker.
`timescale 1ns / 1ps

module tb_unique_key_stack;
    import ukstk_pkg::*;

    localparam int DEPTH        = 16;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 110;
    localparam int LONG_HOLD    = 80;   // reply stall long enough to back up the command side
    localparam int DRAIN_CYCLES = 40;   // idle wait after draining, longer than the longest push

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;

    // Shared between the command and reply processes
    bit   steady;        // no idling on either side
    bit   hold_request;  // ask the reply side for one long stall

    // Recently pushed keys, reused so that duplicates turn up often
    logic [DATA_W-1:0] recent_keys [8];
    int                recent_wr;

    ukstk_cmd_if cmd_ch ();
    ukstk_rsp_if rsp_ch ();

    unique_key_stack #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    ukstk_shadow #(
        .DEPTH(DEPTH)
    ) shadow (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_ch),
        .i_rsp       (rsp_ch),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    // Idle length: mostly none, some short, a few long. Zero in steady stretches.
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Small keys of either sign clash often; recent keys hit live entries;
    // full-range keys exercise every bit.
    function automatic logic [DATA_W-1:0] pick_key();
        int                r;
        logic [DATA_W-1:0] k;
        r = $urandom_range(99);
        if (r < 45) begin
            k = $urandom_range(23);
            if ($urandom_range(1))
                k = -k;
        end else if (r < 70) begin
            k = recent_keys[$urandom_range(7)];
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic t_op pick_op(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return OP_NOP;
        if (r < 3 + push_pct)
            return OP_PUSH;
        if (r < 3 + push_pct + pop_pct)
            return OP_POP;
        return OP_PEEK;
    endfunction

    // One command transaction: optional idle gap, then hold valid until accepted.
    // valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send(input t_op op, input logic [DATA_W-1:0] key,
                        input logic [DATA_W-1:0] value);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.op          <= op;
        cmd_ch.entry_key   <= key;
        cmd_ch.entry_value <= value;
        if (op == OP_PUSH) begin
            recent_keys[recent_wr] = key;
            recent_wr = (recent_wr + 1) % 8;
        end
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait for every outstanding reply
    task automatic pause_for_replies();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Reply side: random stalls, plus one long hold on request
    initial begin : reply_side
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && $urandom_range(99) < 20) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Command side: reset, directed cases, random phases, drain and verdict
    initial begin : command_side
        int  sent;
        int  push_pct;
        int  pop_pct;
        t_op op;

        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = OP_NOP;
        cmd_ch.entry_key   = '0;
        cmd_ch.entry_value = '0;
        steady             = 1'b0;
        hold_request       = 1'b0;
        recent_wr          = 0;
        foreach (recent_keys[i])
            recent_keys[i] = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty stack: pop and peek underflow, unused op code is a no-op
        send(OP_POP,  $urandom, $urandom);
        send(OP_PEEK, $urandom, $urandom);
        send(OP_NOP,  $urandom, $urandom);

        // Extreme keys and values
        send(OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
        send(OP_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
        send(OP_PUSH, 32'h0000_0000, 32'h0000_0000);
        send(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Duplicate of the bottom entry, then peek, no-op on a live stack, pop
        send(OP_PUSH, 32'h8000_0000, 32'h1234_5678);
        send(OP_PEEK, $urandom, $urandom);
        send(OP_NOP,  $urandom, $urandom);
        send(OP_POP,  $urandom, $urandom);

        // Fill to the top, then a new key (full) and a stored key (duplicate wins)
        for (int i = 0; i < DEPTH - 3; i++)
            send(OP_PUSH, 32'hA5A5_0000 + i, $urandom);
        send(OP_PUSH, 32'h0BAD_F00D, $urandom);
        send(OP_PUSH, 32'h0000_0000, $urandom);

        // Random phases cycle through fill-heavy, drain-heavy and mixed traffic
        for (int phase = 0; phase < PHASES; phase++) begin
            steady = (phase == 2 || phase == 7);
            if (phase == 4)
                hold_request = 1'b1;
            case (phase % 3)
                0: begin
                    push_pct = 70;
                    pop_pct  = 20;
                end
                1: begin
                    push_pct = 20;
                    pop_pct  = 65;
                end
                default: begin
                    push_pct = 45;
                    pop_pct  = 40;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                op = pick_op(push_pct, pop_pct);
                send(op, pick_key(), $urandom);
                if (op != OP_NOP)
                    sent++;
            end
            if (phase == 6 || phase == 10)
                pause_for_replies();
        end
        steady = 1'b0;

        // Drain, then give a stray reply time to show up
        pause_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
